// ===== rtl/text_console_number_writer_macros.svh =====
// ----------------------------------------------------------------------------
// text console number writer assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_NUMBER_WRITER_MACROS_SVH
`define TEXT_CONSOLE_NUMBER_WRITER_MACROS_SVH

// same-cycle implication
`define TCNW_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tcnw assertion failed");

// next-cycle implication
`define TCNW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tcnw assertion failed");

`endif

// ===== rtl/tcnw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcnw_pkg
// types, constants and helper functions of the text console number writer
// ----------------------------------------------------------------------------
package tcnw_pkg;

   // grid geometry
   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int POS_W         = 11;
   localparam int ROW_W         = $clog2(ROWS + 1);
   localparam int COL_W         = $clog2(COLUMNS);
   localparam int LAST_ROW_BASE = COLUMNS * (ROWS - 1);

   // payload widths
   localparam int KIND_W  = 3;
   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int OP_W    = 2;

   // number conversion
   localparam int DIGITS        = 10;
   localparam int BCD_W         = 4 * DIGITS;
   localparam int BITS_PER_STEP = 4;
   localparam int DABBLE_STEPS  = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(DABBLE_STEPS);
   localparam int CNT_W         = $clog2(DIGITS + 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHAR   = 3'd0,
      KIND_UDEC   = 3'd1,
      KIND_SDEC   = 3'd2,
      KIND_HEX_LO = 3'd3,
      KIND_HEX_UP = 3'd4,
      KIND_CLEAR  = 3'd5
   } kind_type;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE        = 2'd0,
      OP_SCROLL       = 2'd1,
      OP_CLEAR_ROW    = 2'd2,
      OP_CLEAR_SCREEN = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      MODE_CHAR,
      MODE_DEC,
      MODE_HEX_LO,
      MODE_HEX_UP,
      MODE_CLEAR
   } mode_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CONV,
      F_EMIT
   } front_state_type;

   // csr register indexes
   typedef enum logic [0:0] {
      REG_TEXT_ATTRIBUTE = 1'b0
   } reg_index_type;

   // one character (or clear command) handed from front to back
   typedef struct packed {
      logic              clear;
      logic [CHAR_W-1:0] ch;
      logic              last;
   } queue_entry_type;

   // number of significant digits, at least one
   function automatic logic [CNT_W-1:0] digit_count(input logic [BCD_W-1:0] digits);
      logic [CNT_W-1:0] n;
      n = CNT_W'(1);
      for (int d = 0; d < DIGITS; d++) begin
         if (digits[4*d +: 4] != 4'd0) begin
            n = CNT_W'(d + 1);
         end
      end
      return n;
   endfunction

   // ascii code of one digit
   function automatic logic [CHAR_W-1:0] digit_ascii(input logic [3:0] nib, input logic upper);
      logic [CHAR_W-1:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + CHAR_W'(nib);
      end else if (upper) begin
         c = CHAR_UPPER_A + CHAR_W'(nib - 4'd10);
      end else begin
         c = CHAR_LOWER_A + CHAR_W'(nib - 4'd10);
      end
      return c;
   endfunction

endpackage

// ===== rtl/tcnw_req_if.sv =====
// ----------------------------------------------------------------------------
// tcnw_req_if
// request channel: item kind and value with valid/ready handshake
// ----------------------------------------------------------------------------
interface tcnw_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcnw_pkg::KIND_W-1:0]  kind;
   logic [tcnw_pkg::VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== rtl/tcnw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcnw_rsp_if
// result channel: console operations with valid/ready handshake
// ----------------------------------------------------------------------------
interface tcnw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tcnw_pkg::OP_W-1:0]   op;
   logic [tcnw_pkg::POS_W-1:0]  position;
   logic [tcnw_pkg::CHAR_W-1:0] character;
   logic [tcnw_pkg::ATTR_W-1:0] attribute;
   logic                        last;

   modport source (output valid, output op, output position, output character,
                   output attribute, output last, input ready);
   modport sink   (input valid, input op, input position, input character,
                   input attribute, input last, output ready);
endinterface

// ===== rtl/tcnw_front.sv =====
// ----------------------------------------------------------------------------
// tcnw_front
// accepts requests, converts numbers to digit strings, queues characters
// ----------------------------------------------------------------------------
module tcnw_front (
   input  logic                      clock,
   input  logic                      reset,
   tcnw_req_if.sink                  req_chan,
   input  logic                      q_full,
   output logic                      q_push,
   output tcnw_pkg::queue_entry_type q_entry
);

   tcnw_pkg::front_state_type state_ff, state_in;
   tcnw_pkg::mode_type        mode_ff, mode_in;
   logic [tcnw_pkg::BCD_W-1:0]   dig_ff, dig_in;
   logic [tcnw_pkg::VALUE_W-1:0] bin_ff, bin_in;
   logic [tcnw_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [tcnw_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                         neg_ff, neg_in;

   logic                         accept;
   tcnw_pkg::kind_type           kind;
   logic [tcnw_pkg::BCD_W-1:0]   dab_bcd;
   logic [tcnw_pkg::VALUE_W-1:0] dab_bin;
   logic                         conv_done;
   logic                         entry_last;
   logic [3:0]                   cur_nib;
   logic [tcnw_pkg::CNT_W-1:0]   cur_idx;

   assign accept    = req_chan.valid && req_chan.ready;
   assign kind      = tcnw_pkg::kind_type'(req_chan.kind);
   assign conv_done = (step_ff == tcnw_pkg::STEP_W'(tcnw_pkg::DABBLE_STEPS - 1));
   assign cur_idx   = cnt_ff - tcnw_pkg::CNT_W'(1);
   assign cur_nib   = dig_ff[cur_idx*4 +: 4];

   // double dabble, four binary bits per cycle
   always_comb begin
      dab_bcd = dig_ff;
      dab_bin = bin_ff;
      for (int s = 0; s < tcnw_pkg::BITS_PER_STEP; s++) begin
         for (int d = 0; d < tcnw_pkg::DIGITS; d++) begin
            if (dab_bcd[4*d +: 4] >= 4'd5) begin
               dab_bcd[4*d +: 4] = dab_bcd[4*d +: 4] + 4'd3;
            end
         end
         {dab_bcd, dab_bin} = {dab_bcd[tcnw_pkg::BCD_W-2:0], dab_bin, 1'b0};
      end
   end

   // last character of the item
   always_comb begin
      if (mode_ff == tcnw_pkg::MODE_CHAR || mode_ff == tcnw_pkg::MODE_CLEAR) begin
         entry_last = 1'b1;
      end else begin
         entry_last = !neg_ff && (cnt_ff == tcnw_pkg::CNT_W'(1));
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcnw_pkg::F_IDLE: begin
            if (accept) begin
               unique case (kind)
                  tcnw_pkg::KIND_CHAR: begin
                     if (req_chan.value[tcnw_pkg::CHAR_W-1:0] != tcnw_pkg::CHAR_NUL) begin
                        state_in = tcnw_pkg::F_EMIT;
                     end
                  end
                  tcnw_pkg::KIND_UDEC, tcnw_pkg::KIND_SDEC: state_in = tcnw_pkg::F_CONV;
                  tcnw_pkg::KIND_HEX_LO, tcnw_pkg::KIND_HEX_UP,
                  tcnw_pkg::KIND_CLEAR: state_in = tcnw_pkg::F_EMIT;
                  default: state_in = tcnw_pkg::F_IDLE;
               endcase
            end
         end
         tcnw_pkg::F_CONV: begin
            if (conv_done) begin
               state_in = tcnw_pkg::F_EMIT;
            end
         end
         tcnw_pkg::F_EMIT: begin
            if (q_push && entry_last) begin
               state_in = tcnw_pkg::F_IDLE;
            end
         end
         default: state_in = tcnw_pkg::F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = (state_ff == tcnw_pkg::F_IDLE);
      q_push         = (state_ff == tcnw_pkg::F_EMIT) && !q_full;
      q_entry.clear  = (mode_ff == tcnw_pkg::MODE_CLEAR);
      q_entry.last   = entry_last;
      case (mode_ff)
         tcnw_pkg::MODE_CHAR:  q_entry.ch = dig_ff[tcnw_pkg::CHAR_W-1:0];
         tcnw_pkg::MODE_CLEAR: q_entry.ch = tcnw_pkg::CHAR_NUL;
         default: begin
            if (neg_ff) begin
               q_entry.ch = tcnw_pkg::CHAR_MINUS;
            end else begin
               q_entry.ch = tcnw_pkg::digit_ascii(cur_nib, mode_ff == tcnw_pkg::MODE_HEX_UP);
            end
         end
      endcase
   end

   // datapath next values
   always_comb begin
      mode_in = mode_ff;
      dig_in  = dig_ff;
      bin_in  = bin_ff;
      cnt_in  = cnt_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      if (state_ff == tcnw_pkg::F_IDLE && accept) begin
         step_in = '0;
         neg_in  = 1'b0;
         cnt_in  = tcnw_pkg::CNT_W'(1);
         case (kind)
            tcnw_pkg::KIND_CHAR: begin
               mode_in = tcnw_pkg::MODE_CHAR;
               dig_in  = tcnw_pkg::BCD_W'(req_chan.value[tcnw_pkg::CHAR_W-1:0]);
            end
            tcnw_pkg::KIND_UDEC: begin
               mode_in = tcnw_pkg::MODE_DEC;
               dig_in  = '0;
               bin_in  = req_chan.value;
            end
            tcnw_pkg::KIND_SDEC: begin
               mode_in = tcnw_pkg::MODE_DEC;
               dig_in  = '0;
               neg_in  = req_chan.value[tcnw_pkg::VALUE_W-1];
               bin_in  = req_chan.value[tcnw_pkg::VALUE_W-1] ?
                         (tcnw_pkg::VALUE_W'(0) - req_chan.value) : req_chan.value;
            end
            tcnw_pkg::KIND_HEX_LO, tcnw_pkg::KIND_HEX_UP: begin
               mode_in = (kind == tcnw_pkg::KIND_HEX_UP) ? tcnw_pkg::MODE_HEX_UP :
                                                            tcnw_pkg::MODE_HEX_LO;
               dig_in  = tcnw_pkg::BCD_W'(req_chan.value);
               cnt_in  = tcnw_pkg::digit_count(tcnw_pkg::BCD_W'(req_chan.value));
            end
            tcnw_pkg::KIND_CLEAR: mode_in = tcnw_pkg::MODE_CLEAR;
            default: mode_in = mode_ff;
         endcase
      end else if (state_ff == tcnw_pkg::F_CONV) begin
         dig_in  = dab_bcd;
         bin_in  = dab_bin;
         step_in = step_ff + tcnw_pkg::STEP_W'(1);
         if (conv_done) begin
            cnt_in = tcnw_pkg::digit_count(dab_bcd);
         end
      end else if (q_push) begin
         if (neg_ff) begin
            neg_in = 1'b0;
         end else begin
            cnt_in = cur_idx;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcnw_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff <= mode_in;
      dig_ff  <= dig_in;
      bin_ff  <= bin_in;
      cnt_ff  <= cnt_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
   end

endmodule

// ===== rtl/tcnw_queue.sv =====
// ----------------------------------------------------------------------------
// tcnw_queue
// small first-in first-out queue of characters between front and back
// ----------------------------------------------------------------------------
`include "text_console_number_writer_macros.svh"

module tcnw_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tcnw_pkg::queue_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output tcnw_pkg::queue_entry_type head
);

   tcnw_pkg::queue_entry_type       slot_ff [tcnw_pkg::QUEUE_DEPTH];
   logic [tcnw_pkg::QPTR_W-1:0]     wr_ff, wr_in;
   logic [tcnw_pkg::QPTR_W-1:0]     rd_ff, rd_in;
   logic [tcnw_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == tcnw_pkg::QCNT_W'(tcnw_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ff];

   // pointer and fill count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == tcnw_pkg::QPTR_W'(tcnw_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ff + tcnw_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == tcnw_pkg::QPTR_W'(tcnw_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ff + tcnw_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + tcnw_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - tcnw_pkg::QCNT_W'(1);
      end
   end

   // storage and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   // checks
   `TCNW_ASSERT(a_no_push_when_full, push, !full)
   `TCNW_ASSERT(a_no_pop_when_empty, pop, head_valid)
   `TCNW_ASSERT(a_count_bounded, 1'b1, count_ff <= tcnw_pkg::QCNT_W'(tcnw_pkg::QUEUE_DEPTH))

endmodule

// ===== rtl/tcnw_back.sv =====
// ----------------------------------------------------------------------------
// tcnw_back
// keeps the cursor and turns queued characters into console operations
// ----------------------------------------------------------------------------
`include "text_console_number_writer_macros.svh"

module tcnw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tcnw_pkg::ATTR_W-1:0] attribute,
   input  logic                        q_valid,
   input  tcnw_pkg::queue_entry_type   q_head,
   output logic                        q_pop,
   tcnw_rsp_if.source                  rsp_chan
);

   // cursor as row, column and flat position
   logic [tcnw_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [tcnw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tcnw_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                        phase_ff, phase_in;

   // output register
   logic                         out_valid_ff, out_valid_in;
   tcnw_pkg::op_type             out_op_ff, out_op_in;
   logic [tcnw_pkg::POS_W-1:0]   out_pos_ff, out_pos_in;
   logic [tcnw_pkg::CHAR_W-1:0]  out_ch_ff, out_ch_in;
   logic [tcnw_pkg::ATTR_W-1:0]  out_attr_ff, out_attr_in;
   logic                         out_last_ff, out_last_in;

   logic slot_free;
   logic load;

   assign slot_free = !out_valid_ff || rsp_chan.ready;

   // operation sequencing
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      q_pop       = 1'b0;
      load        = 1'b0;
      out_op_in   = tcnw_pkg::OP_WRITE;
      out_pos_in  = '0;
      out_ch_in   = '0;
      out_attr_in = '0;
      out_last_in = 1'b0;
      if (q_valid && slot_free) begin
         if (q_head.clear) begin
            load        = 1'b1;
            q_pop       = 1'b1;
            out_op_in   = tcnw_pkg::OP_CLEAR_SCREEN;
            out_last_in = q_head.last;
            row_in      = '0;
            col_in      = '0;
            pos_in      = '0;
         end else if (q_head.ch == tcnw_pkg::CHAR_NEWLINE) begin
            if (row_ff >= tcnw_pkg::ROW_W'(tcnw_pkg::ROWS - 1)) begin
               load = 1'b1;
               if (!phase_ff) begin
                  out_op_in = tcnw_pkg::OP_SCROLL;
                  phase_in  = 1'b1;
               end else begin
                  out_op_in   = tcnw_pkg::OP_CLEAR_ROW;
                  out_last_in = q_head.last;
                  phase_in    = 1'b0;
                  q_pop       = 1'b1;
                  row_in      = tcnw_pkg::ROW_W'(tcnw_pkg::ROWS - 1);
                  col_in      = '0;
                  pos_in      = tcnw_pkg::POS_W'(tcnw_pkg::LAST_ROW_BASE);
               end
            end else begin
               // newline inside the grid moves the cursor only
               q_pop  = 1'b1;
               row_in = row_ff + tcnw_pkg::ROW_W'(1);
               col_in = '0;
               pos_in = pos_ff + tcnw_pkg::POS_W'(tcnw_pkg::COLUMNS) -
                        tcnw_pkg::POS_W'(col_ff);
            end
         end else if (row_ff == tcnw_pkg::ROW_W'(tcnw_pkg::ROWS)) begin
            // cursor past the grid: scroll before the write
            load      = 1'b1;
            out_op_in = tcnw_pkg::OP_SCROLL;
            row_in    = tcnw_pkg::ROW_W'(tcnw_pkg::ROWS - 1);
            col_in    = '0;
            pos_in    = tcnw_pkg::POS_W'(tcnw_pkg::LAST_ROW_BASE);
         end else begin
            load        = 1'b1;
            q_pop       = 1'b1;
            out_op_in   = tcnw_pkg::OP_WRITE;
            out_pos_in  = pos_ff;
            out_ch_in   = q_head.ch;
            out_attr_in = attribute;
            out_last_in = q_head.last;
            pos_in      = pos_ff + tcnw_pkg::POS_W'(1);
            if (col_ff == tcnw_pkg::COL_W'(tcnw_pkg::COLUMNS - 1)) begin
               col_in = '0;
               row_in = row_ff + tcnw_pkg::ROW_W'(1);
            end else begin
               col_in = col_ff + tcnw_pkg::COL_W'(1);
            end
         end
      end
   end

   // output valid
   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.op        = out_op_ff;
   assign rsp_chan.position  = out_pos_ff;
   assign rsp_chan.character = out_ch_ff;
   assign rsp_chan.attribute = out_attr_ff;
   assign rsp_chan.last      = out_last_ff;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         pos_ff       <= '0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         out_op_ff   <= out_op_in;
         out_pos_ff  <= out_pos_in;
         out_ch_ff   <= out_ch_in;
         out_attr_ff <= out_attr_in;
         out_last_ff <= out_last_in;
      end
   end

   // checks
   `TCNW_ASSERT(a_row_bounded, 1'b1, row_ff <= tcnw_pkg::ROW_W'(tcnw_pkg::ROWS))
   `TCNW_ASSERT(a_phase_on_newline, phase_ff, q_valid && !q_head.clear && (q_head.ch == tcnw_pkg::CHAR_NEWLINE))

endmodule

// ===== rtl/text_console_number_writer.sv =====
// A character passes from the front's registers through a queue slot into the back's
// output register; a decimal number first runs the conversion steps, a hex number none.
// The front takes one request, then one queued character per cycle while the queue is
// not full, and takes no new request until all characters of a number are queued.
// The back issues one result per cycle while its result slot is free; a scroll goes first.
// Reset clears the cursor, the queue and the output valid, attribute back to 7.
// ----------------------------------------------------------------------------
// text_console_number_writer
// text console writer: characters and numbers to cell writes on a text grid
// ----------------------------------------------------------------------------
module text_console_number_writer (
   input  logic                            clock,
   input  logic                            reset,
   tcnw_req_if.sink                        req_chan,
   tcnw_rsp_if.source                      rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcnw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [tcnw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tcnw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [tcnw_pkg::ATTR_W-1:0] attr_ff, attr_in;
   logic                        csr_write;
   tcnw_pkg::reg_index_type     csr_index;

   logic                        q_full;
   logic                        q_push;
   tcnw_pkg::queue_entry_type   q_entry;
   logic                        q_pop;
   logic                        q_valid;
   tcnw_pkg::queue_entry_type   q_head;

   // register decode, register index from address bit 2
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = tcnw_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      attr_in = attr_ff;
      if (csr_write && csr_index == tcnw_pkg::REG_TEXT_ATTRIBUTE) begin
         attr_in = csr_pwdata[tcnw_pkg::ATTR_W-1:0];
      end
   end

   // register read back
   always_comb begin
      unique case (csr_index)
         tcnw_pkg::REG_TEXT_ATTRIBUTE: csr_prdata = tcnw_pkg::CSR_DATA_W'(attr_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcnw_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // request front end
   tcnw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   // character queue
   tcnw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   // cursor and result back end
   tcnw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .attribute (attr_ff),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== dv/text_console_number_writer_scoreboard.sv =====
// ----------------------------------------------------------------------------
// text console number writer scoreboard
// watches the request, result and register ports of the console writer,
// keeps its own cursor and attribute, predicts the console operations that
// each accepted request causes and compares every result against them
// ----------------------------------------------------------------------------
module text_console_number_writer_scoreboard
   import tcnw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   tcnw_req_if                   req_mon,
   tcnw_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatch_count,
   output int                    ops_outstanding
);

   localparam int LAST_CELL = COLUMNS * ROWS - 1;
   localparam int REPORT_LIMIT = 10;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TEXT_ATTRIBUTE =
      CSR_ADDR_W'(4 * int'(REG_TEXT_ATTRIBUTE));

   typedef struct packed {
      op_type            op;
      logic [POS_W-1:0]  position;
      logic [CHAR_W-1:0] character;
      logic [ATTR_W-1:0] attribute;
      logic              last;
   } console_op_type;

   console_op_type    console_ops_due[$];
   int                cursor;
   logic [ATTR_W-1:0] text_attribute;
   int                failures = 0;

   function automatic void push_op(input op_type op, input int position,
                                   input logic [CHAR_W-1:0] character,
                                   input logic [ATTR_W-1:0] attribute);
      console_op_type entry;
      entry.op        = op;
      entry.position  = POS_W'(position);
      entry.character = character;
      entry.attribute = attribute;
      entry.last      = 1'b0;
      console_ops_due.push_back(entry);
   endfunction

   // one printed character at the cursor, with newline and scroll handling
   function automatic void put_glyph(input logic [CHAR_W-1:0] ch);
      if (ch == CHAR_NEWLINE) begin
         cursor = COLUMNS * (cursor / COLUMNS + 1);
         if (cursor > LAST_CELL) begin
            push_op(OP_SCROLL, 0, '0, '0);
            push_op(OP_CLEAR_ROW, 0, '0, '0);
            cursor = LAST_ROW_BASE;
         end
      end else if (ch != CHAR_NUL) begin
         // grid full: scroll before the write
         if (cursor > LAST_CELL) begin
            push_op(OP_SCROLL, 0, '0, '0);
            cursor = LAST_ROW_BASE;
         end
         push_op(OP_WRITE, cursor, ch, text_attribute);
         cursor++;
      end
   endfunction

   // all console operations caused by one request
   function automatic void predict_console_ops(input logic [KIND_W-1:0] kind,
                                               input logic [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] magnitude;
      logic [3:0]         nibble;
      logic [CHAR_W-1:0]  glyphs[$];
      console_op_type     tail;
      int                 first;
      first = console_ops_due.size();
      magnitude = value;
      case (kind)
         KIND_CHAR: begin
            put_glyph(value[CHAR_W-1:0]);
         end
         KIND_UDEC, KIND_SDEC: begin
            // negating the most negative value leaves 2147483648 unsigned
            if (kind == KIND_SDEC && value[VALUE_W-1]) begin
               magnitude = -value;
            end
            do begin
               glyphs.push_front(CHAR_ZERO + CHAR_W'(magnitude % 10));
               magnitude = magnitude / 10;
            end while (magnitude != 0);
            if (kind == KIND_SDEC && value[VALUE_W-1]) begin
               glyphs.push_front(CHAR_MINUS);
            end
         end
         KIND_HEX_LO, KIND_HEX_UP: begin
            do begin
               nibble = magnitude[3:0];
               if (nibble < 4'd10) begin
                  glyphs.push_front(CHAR_ZERO + CHAR_W'(nibble));
               end else if (kind == KIND_HEX_UP) begin
                  glyphs.push_front(CHAR_UPPER_A + CHAR_W'(nibble - 4'd10));
               end else begin
                  glyphs.push_front(CHAR_LOWER_A + CHAR_W'(nibble - 4'd10));
               end
               magnitude = magnitude >> 4;
            end while (magnitude != 0);
         end
         KIND_CLEAR: begin
            cursor = 0;
            push_op(OP_CLEAR_SCREEN, 0, '0, '0);
         end
         default: begin
            // reserved kinds do nothing
         end
      endcase
      foreach (glyphs[i]) begin
         put_glyph(glyphs[i]);
      end
      // flag the final operation of this request
      if (console_ops_due.size() > first) begin
         tail = console_ops_due.pop_back();
         tail.last = 1'b1;
         console_ops_due.push_back(tail);
      end
   endfunction

   function automatic void log_failure(input string what, input console_op_type want,
                                       input console_op_type got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%0t %s", $time, what);
         $display("   expected op=%0d pos=%0d char=%02h attr=%02h last=%0b",
                  want.op, want.position, want.character, want.attribute, want.last);
         $display("   actual   op=%0d pos=%0d char=%02h attr=%02h last=%0b",
                  got.op, got.position, got.character, got.attribute, got.last);
      end
   endfunction

   // compare results, then predict new requests, then follow register writes
   always @(posedge clock) begin
      console_op_type want;
      console_op_type got;
      if (reset) begin
         cursor = 0;
         text_attribute = ATTR_RESET;
         console_ops_due.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got.op        = op_type'(rsp_mon.op);
            got.position  = rsp_mon.position;
            got.character = rsp_mon.character;
            got.attribute = rsp_mon.attribute;
            got.last      = rsp_mon.last;
            if (console_ops_due.size() == 0) begin
               log_failure("result with nothing expected", '0, got);
            end else begin
               want = console_ops_due.pop_front();
               if (got !== want) begin
                  log_failure("result mismatch", want, got);
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            predict_console_ops(req_mon.kind, req_mon.value);
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == ADDR_TEXT_ATTRIBUTE) begin
            text_attribute = csr_pwdata[ATTR_W-1:0];
         end
      end
      mismatch_count  <= failures;
      ops_outstanding <= console_ops_due.size();
   end

endmodule

// ===== dv/text_console_number_writer_tb.sv =====
// ----------------------------------------------------------------------------
// text console number writer testbench
// drives characters, decimal and hex numbers and clear commands into the
// console writer with random gaps and result stalls, changes the attribute
// register between phases, and reports the scoreboard verdict
// ----------------------------------------------------------------------------
module text_console_number_writer_tb;
   import tcnw_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 24;
   localparam int PHASE_ITEMS  = 48;
   localparam int LAST_ITEMS   = 46;
   localparam logic [KIND_W-1:0] KIND_RESERVED_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RESERVED_HI = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] ADDR_TEXT_ATTRIBUTE =
      CSR_ADDR_W'(4 * int'(REG_TEXT_ATTRIBUTE));

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int ops_outstanding;
   int cycle_count = 0;
   bit idling_on = 1'b1;

   tcnw_req_if req_bus ();
   tcnw_rsp_if rsp_bus ();

   text_console_number_writer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   text_console_number_writer_scoreboard u_scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .mismatch_count  (mismatch_count),
      .ops_outstanding (ops_outstanding)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[text_console_number_writer] ERROR");
         $finish;
      end
   end

   // result side ready: random stall bursts while idling is on
   initial begin
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // one request, held until accepted; valid stays high afterwards
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [VALUE_W-1:0] value);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.kind  = kind;
      req_bus.value = value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // wait for all results, then for work that causes none
   task automatic settle();
      req_bus.valid = 1'b0;
      while (ops_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // one random request of any kind; ignored ones do not count
   task automatic send_random_item(inout int budget);
      int                 pick;
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      pick  = $urandom_range(0, 99);
      value = $urandom() >> $urandom_range(0, 31);
      if (pick < 25) begin
         kind = KIND_CHAR;
         value = $urandom();
         value[CHAR_W-1:0] = CHAR_W'($urandom_range(32, 126));
      end else if (pick < 32) begin
         kind = KIND_CHAR;
         value = $urandom();
         value[CHAR_W-1:0] = CHAR_NEWLINE;
      end else if (pick < 35) begin
         kind = KIND_CHAR;
         value = $urandom();
      end else if (pick < 37) begin
         kind = KIND_CHAR;
         value = $urandom();
         value[CHAR_W-1:0] = CHAR_NUL;
      end else if (pick < 50) begin
         kind = KIND_UDEC;
      end else if (pick < 62) begin
         kind = KIND_SDEC;
         if ($urandom_range(0, 1) == 1) begin
            value = -value;
         end
      end else if (pick < 78) begin
         kind = KIND_HEX_LO;
      end else if (pick < 94) begin
         kind = KIND_HEX_UP;
      end else if (pick < 96) begin
         kind = KIND_CLEAR;
         value = $urandom();
      end else begin
         kind = ($urandom_range(0, 1) == 1) ? KIND_RESERVED_HI : KIND_RESERVED_LO;
         value = $urandom();
      end
      send_request(kind, value);
      if (kind <= KIND_CLEAR && !(kind == KIND_CHAR && value[CHAR_W-1:0] == CHAR_NUL)) begin
         budget--;
      end
   endtask

   // mix of single requests, newline runs of up to one screen height and hex number runs
   task automatic run_random_phase(input int items);
      int                 budget;
      int                 pick;
      logic [VALUE_W-1:0] value;
      budget = items;
      while (budget > 0) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            send_random_item(budget);
         end else if (pick < 8) begin
            repeat ($urandom_range(1, ROWS)) begin
               value = $urandom();
               value[CHAR_W-1:0] = CHAR_NEWLINE;
               send_request(KIND_CHAR, value);
               budget--;
            end
         end else begin
            // eight-digit hex numbers run past the end of a row
            repeat ($urandom_range(8, 11)) begin
               send_request(($urandom_range(0, 1) == 1) ? KIND_HEX_UP : KIND_HEX_LO,
                            $urandom() | 32'h1000_0000);
               budget--;
            end
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_CHAR;
      req_bus.value = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, every kind, reset attribute
      send_request(KIND_CHAR, 32'h0000_0041);
      send_request(KIND_CHAR, 32'hFFFF_FF7E);
      send_request(KIND_CHAR, 32'h0000_00FF);
      send_request(KIND_CHAR, 32'hABCD_EF00);
      send_request(KIND_CHAR, {24'hFFFFFF, CHAR_NEWLINE});
      send_request(KIND_UDEC, 32'h0000_0000);
      send_request(KIND_UDEC, 32'hFFFF_FFFF);
      send_request(KIND_SDEC, 32'h8000_0000);
      send_request(KIND_SDEC, 32'hFFFF_FFFF);
      send_request(KIND_SDEC, 32'h7FFF_FFFF);
      send_request(KIND_SDEC, 32'h0000_0000);
      send_request(KIND_HEX_LO, 32'h0000_0000);
      send_request(KIND_HEX_LO, 32'hDEAD_BEEF);
      send_request(KIND_HEX_UP, 32'hFFFF_FFFF);
      send_request(KIND_HEX_UP, 32'h0ABC_DEF0);
      send_request(KIND_RESERVED_LO, 32'hFFFF_FFFF);
      send_request(KIND_RESERVED_HI, 32'h1234_5678);
      send_request(KIND_CHAR, {24'h000000, CHAR_NEWLINE});
      send_request(KIND_HEX_LO, 32'h0000_000A);
      send_request(KIND_CLEAR, 32'hFFFF_FFFF);
      send_request(KIND_CHAR, 32'h0000_0030);
      settle();

      // random phases, attribute extremes between them
      write_csr(ADDR_TEXT_ATTRIBUTE, 32'hFFFF_FFFF);
      run_random_phase(PHASE_ITEMS);
      settle();
      write_csr(ADDR_TEXT_ATTRIBUTE, 32'h0000_0000);
      run_random_phase(PHASE_ITEMS);
      settle();
      write_csr(ADDR_TEXT_ATTRIBUTE, $urandom());
      run_random_phase(PHASE_ITEMS);
      settle();

      // closing phase runs without idling
      idling_on = 1'b0;
      write_csr(ADDR_TEXT_ATTRIBUTE, $urandom());
      run_random_phase(LAST_ITEMS);
      settle();

      if (mismatch_count == 0 && ops_outstanding == 0) begin
         $display("[text_console_number_writer] OK");
      end else begin
         $display("[text_console_number_writer] ERROR");
      end
      $finish;
   end

endmodule
